[rtl/gaussian_soft_vertex_displace_macros.svh]
// Assertion macros shared by the Gaussian soft-selection block.
// Used only by the top level; needs aclk and aresetn in scope where expanded.
`ifndef GAUSSIAN_SOFT_VERTEX_DISPLACE_MACROS_SVH
`define GAUSSIAN_SOFT_VERTEX_DISPLACE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GSVD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked during reset as well.
`define GSVD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/gsvd_pkg.sv]
// Package for the Gaussian soft-selection block: payload types, widths and
// the fraction table of the exponential. No dependencies.
`default_nettype none

package gsvd_pkg;

    localparam int FRAC_BITS         = 16;
    localparam int EXP_TABLE_ENTRIES = 256;
    localparam int ONE               = 1 << FRAC_BITS;

    localparam int COORD_W  = 24;
    localparam int SCALE_W  = 23;
    localparam int WEIGHT_W = 17;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * COORD_W + 1;
    localparam int D2_W     = SQ_W + 2;
    localparam int D2F_W    = D2_W - FRAC_BITS;
    localparam int LO_W     = 18;
    localparam int HI_W     = D2F_W - LO_W;
    localparam int PROD_W   = D2F_W + SCALE_W + 1;
    localparam int X_INT_LIMIT = 64;
    localparam int N_W      = 7;
    localparam int X_W      = N_W + FRAC_BITS;
    localparam int ROM_W    = 33;
    localparam int IDX_W    = $clog2(EXP_TABLE_ENTRIES + 1);
    localparam int POS_W    = FRAC_BITS + IDX_W;
    localparam int CHAIN_LEN = X_INT_LIMIT;
    localparam int CFG_IDX_W = 3;

    localparam logic [30:0] E_INV_Q32 = 31'd1580030169;
    localparam logic [PROD_W-1:0] X_LIMIT_PROD = PROD_W'(X_INT_LIMIT + 1) << (2 * FRAC_BITS);
    localparam logic [X_W-1:0] X_SAT = X_W'(X_INT_LIMIT + 1) << FRAC_BITS;

    localparam logic [WEIGHT_W-1:0] W_ONE  = WEIGHT_W'(ONE);
    localparam logic [WEIGHT_W-1:0] W_HALF = WEIGHT_W'(ONE / 2);
    localparam logic [WEIGHT_W-1:0] W_P8   = WEIGHT_W'((ONE * 4 + 2) / 5);
    localparam logic [WEIGHT_W-1:0] W_P3   = WEIGHT_W'((ONE * 3 + 5) / 10);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_SHIFT_X  = 3'd3,
        REG_SHIFT_Y  = 3'd4,
        REG_SHIFT_Z  = 3'd5,
        REG_FALLOFF  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] moved_x;
        logic signed [COORD_W-1:0] moved_y;
        logic signed [COORD_W-1:0] moved_z;
        logic [WEIGHT_W-1:0]       weight;
        logic [WEIGHT_W-1:0]       shade_red;
        logic [WEIGHT_W-1:0]       shade_green;
        logic [WEIGHT_W-1:0]       shade_blue;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic signed [COORD_W-1:0] shift_x;
        logic signed [COORD_W-1:0] shift_y;
        logic signed [COORD_W-1:0] shift_z;
        logic [SCALE_W-1:0]        falloff_scale;
    } cfg_t;

    typedef logic [ROM_W-1:0] exp_rom_t [0:EXP_TABLE_ENTRIES];

    // Table of e^-(i/N) in Q1.32, summed from a truncated Taylor series.
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        logic [63:0] t;
        logic [63:0] term;
        longint      sum;
        for (int i = 0; i <= EXP_TABLE_ENTRIES; i++) begin
            if (i >= EXP_TABLE_ENTRIES) begin
                rom[i] = ROM_W'(E_INV_Q32);
            end else begin
                t    = (64'(i) << 32) / EXP_TABLE_ENTRIES;
                term = 64'd1 << 32;
                sum  = 0;
                for (int k = 0; k < 40; k++) begin
                    if (term != 64'd0) begin
                        if ((k % 2) == 1) begin
                            sum = sum - longint'(term);
                        end else begin
                            sum = sum + longint'(term);
                        end
                        term = ((term * t) >> 32) / 64'(k + 1);
                    end
                end
                if (sum < 0) begin
                    sum = 0;
                end
                if (sum > (longint'(1) << 32)) begin
                    sum = longint'(1) << 32;
                end
                rom[i] = ROM_W'(sum);
            end
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

`default_nettype wire

[rtl/gaussian_soft_vertex_displace.sv]
// Top level of the Gaussian soft-selection block; holds the registers.
// Depends on gsvd_pkg, gsvd_dist, gsvd_exp, gsvd_out and the macro header.
`default_nettype none

`include "gaussian_soft_vertex_displace_macros.svh"

// One vertex is taken per cycle while s_ready is high. In the pipeline, five
// stages form the scaled squared distance, two read and interpolate the
// exponential table, one stage for each of the 64 possible whole units of the
// exponent multiplies by 1/e, one rounds the weight, and two form the moved
// vertex and the shade. The whole pipeline advances together; when the output
// register holds a result that is not taken, every stage holds and s_ready is
// low. Registers are written through cfg_wr_en, cfg_index and cfg_wdata and
// must only change while no transfer is in flight.
module gaussian_soft_vertex_displace (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [gsvd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gsvd_pkg::COORD_W-1:0]        cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  gsvd_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output gsvd_pkg::out_item_t                 m_data
);
    import gsvd_pkg::*;

    cfg_t                cfg_reg;
    logic                en;
    logic                dist_valid, exp_valid;
    in_item_t            dist_item, exp_item;
    logic [X_W-1:0]      dist_x;
    logic [WEIGHT_W-1:0] exp_weight;
    logic                shades_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{center_x: '0, center_y: '0, center_z: '0,
                         shift_x: '0, shift_y: '0, shift_z: '0,
                         falloff_scale: SCALE_W'(2 * ONE)};
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_CENTER_X: cfg_reg.center_x      <= cfg_wdata;
                REG_CENTER_Y: cfg_reg.center_y      <= cfg_wdata;
                REG_CENTER_Z: cfg_reg.center_z      <= cfg_wdata;
                REG_SHIFT_X:  cfg_reg.shift_x       <= cfg_wdata;
                REG_SHIFT_Y:  cfg_reg.shift_y       <= cfg_wdata;
                REG_SHIFT_Z:  cfg_reg.shift_z       <= cfg_wdata;
                REG_FALLOFF:  cfg_reg.falloff_scale <= cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    gsvd_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_item   (s_data),
        .cfg       (cfg_reg),
        .out_valid (dist_valid),
        .out_item  (dist_item),
        .out_x     (dist_x)
    );

    gsvd_exp u_exp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (dist_valid),
        .in_item    (dist_item),
        .in_x       (dist_x),
        .out_valid  (exp_valid),
        .out_item   (exp_item),
        .out_weight (exp_weight)
    );

    gsvd_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (exp_valid),
        .in_item   (exp_item),
        .in_weight (exp_weight),
        .cfg       (cfg_reg),
        .out_valid (m_valid),
        .out_item  (m_data)
    );

    assign shades_full = m_data.shade_red == W_ONE && m_data.shade_green == W_ONE
                         && m_data.shade_blue == W_ONE;

    `GSVD_ASSERT_NOW(a_weight_range, m_valid, m_data.weight <= W_ONE)
    `GSVD_ASSERT_NOW(a_zero_weight_shade, m_valid && m_data.weight == '0, shades_full)
    `GSVD_ASSERT_NOW(a_full_weight_red, m_valid && m_data.weight == W_ONE, shades_full)
    `GSVD_ASSERT_NEXT(a_reset_empty, !aresetn, !m_valid)

endmodule

`default_nettype wire

[rtl/gsvd_dist.sv]
// Distance stages: squared distance to the center times the falloff scale.
// Depends on gsvd_pkg. Five register stages, all advancing on en.
`default_nettype none

module gsvd_dist (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  gsvd_pkg::in_item_t         in_item,
    input  gsvd_pkg::cfg_t             cfg,
    output logic                       out_valid,
    output gsvd_pkg::in_item_t         out_item,
    output logic [gsvd_pkg::X_W-1:0]   out_x
);
    import gsvd_pkg::*;

    localparam int STAGES = 5;

    logic [STAGES-1:0] valid_reg;
    in_item_t          item_reg [0:STAGES-1];

    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [DIFF_W-1:0] dx_next, dy_next, dz_next;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg, sqz_reg;
    logic signed [2*DIFF_W-1:0] sqx_full, sqy_full, sqz_full;
    logic [D2_W-1:0]          d2_sum;
    logic [D2F_W-1:0]         d2f_reg;
    logic [LO_W+SCALE_W-1:0]  plo_reg, plo_next;
    logic [HI_W+SCALE_W-1:0]  phi_reg, phi_next;
    logic [PROD_W-1:0]        prod;
    logic [X_W-1:0]           x_reg, x_next;

    always_comb begin
        dx_next  = DIFF_W'(in_item.pos_x) - DIFF_W'(cfg.center_x);
        dy_next  = DIFF_W'(in_item.pos_y) - DIFF_W'(cfg.center_y);
        dz_next  = DIFF_W'(in_item.pos_z) - DIFF_W'(cfg.center_z);
        sqx_full = dx_reg * dx_reg;
        sqy_full = dy_reg * dy_reg;
        sqz_full = dz_reg * dz_reg;
        d2_sum   = D2_W'(sqx_reg) + D2_W'(sqy_reg) + D2_W'(sqz_reg);
        // The scale product is split in two halves to keep each multiplier narrow.
        plo_next = d2f_reg[LO_W-1:0] * cfg.falloff_scale;
        phi_next = d2f_reg[D2F_W-1:LO_W] * cfg.falloff_scale;
        prod     = PROD_W'(plo_reg) + (PROD_W'(phi_reg) << LO_W);
        if (prod > X_LIMIT_PROD) begin
            x_next = X_SAT;
        end else begin
            x_next = prod[FRAC_BITS +: X_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[0] <= in_item;
            for (int i = 1; i < STAGES; i++) begin
                item_reg[i] <= item_reg[i-1];
            end
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            dz_reg  <= dz_next;
            sqx_reg <= sqx_full[SQ_W-1:0];
            sqy_reg <= sqy_full[SQ_W-1:0];
            sqz_reg <= sqz_full[SQ_W-1:0];
            d2f_reg <= d2_sum[D2_W-1:FRAC_BITS];
            plo_reg <= plo_next;
            phi_reg <= phi_next;
            x_reg   <= x_next;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_item  = item_reg[STAGES-1];
    assign out_x     = x_reg;

endmodule

`default_nettype wire

[rtl/gsvd_exp.sv]
// Exponential stages: table lookup with interpolation, then one stage per
// whole unit of the exponent multiplying by 1/e. Depends on gsvd_pkg.
`default_nettype none

module gsvd_exp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  gsvd_pkg::in_item_t              in_item,
    input  logic [gsvd_pkg::X_W-1:0]        in_x,
    output logic                            out_valid,
    output gsvd_pkg::in_item_t              out_item,
    output logic [gsvd_pkg::WEIGHT_W-1:0]   out_weight
);
    import gsvd_pkg::*;

    // Table stage, interpolation stage, the 1/e chain and the rounding stage.
    localparam int STAGES = CHAIN_LEN + 3;

    logic [STAGES-1:0] valid_reg;
    in_item_t          item_reg [0:STAGES-1];

    logic [POS_W-1:0]     tpos;
    logic [IDX_W-1:0]     idx;
    logic [ROM_W-1:0]     a_reg, b_reg;
    logic [FRAC_BITS-1:0] rem_reg;
    logic [N_W-1:0]       n_reg [0:CHAIN_LEN+1];
    logic [ROM_W-1:0]     val_reg [0:CHAIN_LEN];
    logic [ROM_W-1:0]     interp_next;
    logic [ROM_W+FRAC_BITS-1:0] slope;
    logic [ROM_W-1:0]     val_next [0:CHAIN_LEN-1];
    logic [FRAC_BITS+2:0] w_round;
    logic [WEIGHT_W-1:0]  w_reg, w_next;

    always_comb begin
        tpos = POS_W'(in_x[FRAC_BITS-1:0]) * POS_W'(EXP_TABLE_ENTRIES);
        idx  = tpos[POS_W-1:FRAC_BITS];
        slope = (a_reg - b_reg) * (ROM_W+FRAC_BITS)'(rem_reg);
        if (a_reg >= b_reg) begin
            interp_next = a_reg - slope[FRAC_BITS +: ROM_W];
        end else begin
            interp_next = a_reg;
        end
        w_round = (FRAC_BITS+3)'(val_reg[CHAIN_LEN] >> FRAC_BITS)
                + (FRAC_BITS+3)'(val_reg[CHAIN_LEN][FRAC_BITS-1]);
        if (n_reg[CHAIN_LEN+1] > N_W'(X_INT_LIMIT)) begin
            w_next = '0;
        end else if (w_round > (FRAC_BITS+3)'(ONE)) begin
            w_next = W_ONE;
        end else begin
            w_next = w_round[WEIGHT_W-1:0];
        end
    end

    genvar k;
    generate
        for (k = 0; k < CHAIN_LEN; k++) begin : g_chain
            logic [63:0] mul;
            assign mul = 64'(val_reg[k]) * 64'(E_INV_Q32) + 64'h8000_0000;
            assign val_next[k] = (N_W'(k) < n_reg[k+1]) ? ROM_W'(mul[63:32]) : val_reg[k];
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[0] <= in_item;
            for (int i = 1; i < STAGES; i++) begin
                item_reg[i] <= item_reg[i-1];
            end
            a_reg    <= EXP_ROM[idx];
            b_reg    <= EXP_ROM[idx + IDX_W'(1)];
            rem_reg  <= tpos[FRAC_BITS-1:0];
            n_reg[0] <= in_x[X_W-1:FRAC_BITS];
            for (int i = 1; i <= CHAIN_LEN + 1; i++) begin
                n_reg[i] <= n_reg[i-1];
            end
            val_reg[0] <= interp_next;
            for (int i = 1; i <= CHAIN_LEN; i++) begin
                val_reg[i] <= val_next[i-1];
            end
            w_reg <= w_next;
        end
    end

    assign out_valid  = valid_reg[STAGES-1];
    assign out_item   = item_reg[STAGES-1];
    assign out_weight = w_reg;

endmodule

`default_nettype wire

[rtl/gsvd_out.sv]
// Output stages: displacement by shift times weight with saturation, and the
// heat-map shade. Depends on gsvd_pkg. The last stage is the output register.
`default_nettype none

module gsvd_out (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  gsvd_pkg::in_item_t              in_item,
    input  logic [gsvd_pkg::WEIGHT_W-1:0]   in_weight,
    input  gsvd_pkg::cfg_t                  cfg,
    output logic                            out_valid,
    output gsvd_pkg::out_item_t             out_item
);
    import gsvd_pkg::*;

    localparam int MP_W = COORD_W + WEIGHT_W + 1;
    localparam int D_W  = MP_W - FRAC_BITS + 1;
    localparam int R_W  = D_W + 2;

    typedef logic signed [MP_W-1:0] mprod_t;

    logic [1:0]          valid_reg;
    in_item_t            item_reg;
    logic [WEIGHT_W-1:0] w_reg;
    mprod_t              mp_reg [0:2];
    mprod_t              mp_next [0:2];
    out_item_t           out_reg, out_next;

    function automatic logic signed [COORD_W-1:0] move_axis(
        input logic signed [COORD_W-1:0] p,
        input mprod_t                    mp
    );
        logic [MP_W-1:0]         mag;
        logic [MP_W:0]           rounded;
        logic signed [R_W-1:0]   d;
        logic signed [R_W-1:0]   r;
        mag     = mp[MP_W-1] ? MP_W'(-mp) : MP_W'(mp);
        rounded = (MP_W+1)'(mag) + (MP_W+1)'(ONE / 2);
        d       = R_W'(rounded >> FRAC_BITS);
        r       = mp[MP_W-1] ? R_W'(p) - d : R_W'(p) + d;
        if (r > R_W'(2 ** (COORD_W - 1) - 1)) begin
            r = R_W'(2 ** (COORD_W - 1) - 1);
        end
        if (r < -R_W'(2 ** (COORD_W - 1))) begin
            r = -R_W'(2 ** (COORD_W - 1));
        end
        return r[COORD_W-1:0];
    endfunction

    always_comb begin
        mp_next[0] = MP_W'(cfg.shift_x) * $signed({1'b0, in_weight});
        mp_next[1] = MP_W'(cfg.shift_y) * $signed({1'b0, in_weight});
        mp_next[2] = MP_W'(cfg.shift_z) * $signed({1'b0, in_weight});

        out_next.moved_x     = move_axis(item_reg.pos_x, mp_reg[0]);
        out_next.moved_y     = move_axis(item_reg.pos_y, mp_reg[1]);
        out_next.moved_z     = move_axis(item_reg.pos_z, mp_reg[2]);
        out_next.weight      = w_reg;
        out_next.shade_red   = W_ONE;
        out_next.shade_green = W_ONE;
        out_next.shade_blue  = W_ONE;
        // Each band is open at both ends; outside it the channel is full scale.
        if (w_reg > W_HALF && w_reg < W_ONE) begin
            out_next.shade_red = (w_reg - W_HALF) << 1;
        end
        if (w_reg < W_P8 && w_reg > W_P3) begin
            out_next.shade_green = (w_reg - W_P3) << 1;
        end
        if (w_reg != '0 && w_reg < W_HALF) begin
            out_next.shade_blue = w_reg << 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= in_item;
            w_reg    <= in_weight;
            for (int i = 0; i < 3; i++) begin
                mp_reg[i] <= mp_next[i];
            end
            out_reg <= out_next;
        end
    end

    assign out_valid = valid_reg[1];
    assign out_item  = out_reg;

endmodule

`default_nettype wire

[verif/gaussian_soft_vertex_displace_tb.sv]
// Self-checking testbench for the Gaussian soft-selection vertex block.
// Depends on gsvd_pkg and the gaussian_soft_vertex_displace top level.
`timescale 1ns / 1ps

module gaussian_soft_vertex_displace_tb;
    import gsvd_pkg::*;

    localparam int LATENCY = 74;
    localparam int WATCHDOG_LIMIT = 4000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;

    gaussian_soft_vertex_displace dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #1 aclk = ~aclk;

    // Model copy of the registers.
    logic signed [COORD_W-1:0] center [3];
    logic signed [COORD_W-1:0] shift [3];
    logic [SCALE_W-1:0] falloff;

    in_item_t pending_vertices [$];
    out_item_t expected_results [$];
    int errors = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int draw_gap = 0;
    int take_gap = 0;
    bit gaps_on = 1'b1;

    // e^-(i/N) in Q1.32, built by a truncated series.
    function automatic logic [63:0] frac_exp_entry(logic [63:0] i);
        logic [63:0] t;
        logic [63:0] term;
        longint acc;
        if (i >= EXP_TABLE_ENTRIES) return 64'd1580030169;
        t = (i << 32) / EXP_TABLE_ENTRIES;
        term = 64'd1 << 32;
        acc = 0;
        for (int k = 0; k < 40; k++) begin
            if (term != 0) begin
                acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
                term = ((term * t) >> 32) / 64'(k + 1);
            end
        end
        if (acc < 0) acc = 0;
        if (acc > (longint'(1) << 32)) acc = longint'(1) << 32;
        return 64'(acc);
    endfunction

    function automatic logic [63:0] falloff_weight(logic [63:0] x);
        logic [63:0] n, fr, pos, idx, rem, a, b, v, w;
        n = x >> FRAC_BITS;
        fr = x & (ONE - 1);
        if (n > X_INT_LIMIT) return 0;
        pos = fr * EXP_TABLE_ENTRIES;
        idx = pos >> FRAC_BITS;
        rem = pos & (ONE - 1);
        a = frac_exp_entry(idx);
        b = frac_exp_entry(idx + 1);
        v = (a >= b) ? a - (((a - b) * rem) >> FRAC_BITS) : a;
        for (int k = 0; k < n; k++)
            if (v != 0) v = (v * 64'd1580030169 + 64'h80000000) >> 32;
        w = (v * ONE + 64'h80000000) >> 32;
        return (w > ONE) ? 64'(ONE) : w;
    endfunction

    function automatic logic signed [COORD_W-1:0] displace(longint p, longint s, longint w);
        longint prod, mag, d, r;
        prod = s * w;
        mag = (prod < 0) ? -prod : prod;
        d = (mag + (ONE >> 1)) >>> FRAC_BITS;
        r = p + ((prod < 0) ? -d : d);
        if (r > 8388607) r = 8388607;
        if (r < -8388608) r = -8388608;
        return r[COORD_W-1:0];
    endfunction

    function automatic out_item_t predict_displacement(in_item_t v);
        out_item_t o;
        longint p [3];
        logic [63:0] d2, d2f, x, w, p8, p3;
        p[0] = v.pos_x; p[1] = v.pos_y; p[2] = v.pos_z;
        d2 = 0;
        for (int j = 0; j < 3; j++) d2 += 64'((p[j] - center[j]) * (p[j] - center[j]));
        d2f = d2 >> FRAC_BITS;
        if (falloff != 0 && d2f > ((64'(X_INT_LIMIT) + 1) << (2 * FRAC_BITS)) / falloff)
            x = (64'(X_INT_LIMIT) + 1) << FRAC_BITS;
        else
            x = (d2f * falloff) >> FRAC_BITS;
        w = falloff_weight(x);
        p8 = (ONE * 4 + 2) / 5;
        p3 = (ONE * 3 + 5) / 10;
        o.moved_x = displace(p[0], shift[0], w);
        o.moved_y = displace(p[1], shift[1], w);
        o.moved_z = displace(p[2], shift[2], w);
        o.weight = w[WEIGHT_W-1:0];
        o.shade_red = (w > ONE / 2 && w < ONE) ? WEIGHT_W'((w - ONE / 2) * 2) : W_ONE;
        o.shade_green = (w < p8 && w > p3) ? WEIGHT_W'((w - p3) * 2) : W_ONE;
        o.shade_blue = (w > 0 && w < ONE / 2) ? WEIGHT_W'(w * 2) : W_ONE;
        return o;
    endfunction

    // Driver: one transfer per item, with a random gap after each while gaps_on
    // is set. A zero gap keeps valid high so that items follow back to back.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                void'(pending_vertices.pop_front());
                draw_gap = gaps_on ? $urandom_range(0, 12) : 0;
                if (draw_gap == 0 && pending_vertices.size() > 0) begin
                    s_data <= pending_vertices[0];
                    expected_results.insert(expected_results.size(),
                                            predict_displacement(pending_vertices[0]));
                end else begin
                    send_gap <= (draw_gap > 0) ? draw_gap - 1 : 0;
                    s_valid <= 1'b0;
                end
            end else if (!s_valid) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (pending_vertices.size() > 0) begin
                    s_data <= pending_vertices[0];
                    s_valid <= 1'b1;
                    expected_results.insert(expected_results.size(),
                                            predict_displacement(pending_vertices[0]));
                end
            end
        end
    end

    // Monitor: compares each result with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result %h", $time, m_data);
                    errors++;
                end else begin
                    if (m_data !== expected_results[0]) begin
                        $display("%0t mismatch: expected %h actual %h", $time,
                                 expected_results[0], m_data);
                        errors++;
                    end
                    void'(expected_results.pop_front());
                end
                take_gap = gaps_on ? $urandom_range(0, 12) : 0;
            end else if (take_gap > 0) begin
                take_gap--;
            end
            m_ready <= (take_gap == 0);
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles > WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [COORD_W-1:0] value);
        cfg_index <= idx;
        cfg_wdata <= value;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z: center[int'(idx)] = value;
            REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z: shift[int'(idx) - 3] = value;
            default: falloff = value[SCALE_W-1:0];
        endcase
        @(posedge aclk);
    endtask

    task automatic drain();
        while (pending_vertices.size() > 0 || expected_results.size() > 0 || s_valid)
            @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    function automatic logic [COORD_W-1:0] rand_coord(int spread);
        if (spread == 0) return COORD_W'($urandom);
        return COORD_W'($urandom_range(0, 2 * spread) - spread);
    endfunction

    task automatic queue_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                logic [COORD_W-1:0] z);
        in_item_t v;
        v.pos_x = x; v.pos_y = y; v.pos_z = z;
        pending_vertices.insert(pending_vertices.size(), v);
    endtask

    initial begin
        int spread;
        for (int j = 0; j < 3; j++) begin
            center[j] = '0;
            shift[j] = '0;
        end
        falloff = SCALE_W'(131072);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: weight one at the origin, zero at the extremes, partial near the origin.
        queue_vertex('0, '0, '0);
        queue_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        queue_vertex(24'h800000, 24'h800000, 24'h800000);
        queue_vertex(24'h008000, '0, '0);
        queue_vertex(24'h00C000, 24'h004000, '0);
        drain();

        // Full-scale shift saturates; center and shift at the extremes.
        write_reg(REG_CENTER_X, 24'h7FFFFF);
        write_reg(REG_CENTER_Y, 24'h800000);
        write_reg(REG_CENTER_Z, '0);
        write_reg(REG_SHIFT_X, 24'h7FFFFF);
        write_reg(REG_SHIFT_Y, 24'h800000);
        write_reg(REG_SHIFT_Z, 24'h010000);
        write_reg(REG_FALLOFF, 24'h000100);
        queue_vertex(24'h7FFFFF, 24'h800000, '0);
        queue_vertex(24'h7F0000, 24'h810000, 24'h010000);
        queue_vertex(24'h000000, 24'h000000, 24'h000000);
        queue_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h800000);
        for (int i = 0; i < 6; i++)
            queue_vertex(24'h7FFFFF - 24'(i * 24'h004000), 24'h800000, '0);
        drain();

        // Zero falloff: weight is one everywhere.
        write_reg(REG_FALLOFF, '0);
        queue_vertex(24'h123456, 24'h800000, 24'h7FFFFF);
        queue_vertex('0, '0, '0);
        drain();
        write_reg(REG_FALLOFF, 24'h7FFFFF);
        queue_vertex(24'h7FFFFF, 24'h800001, 24'h000001);
        queue_vertex(24'h7FFFFF, 24'h800000, 24'h000000);
        drain();

        // Random phases with fresh settings; spread keeps weights in range.
        for (int phase = 0; phase < 8; phase++) begin
            gaps_on = (phase % 4 != 3);
            for (int r = 0; r < 6; r++)
                write_reg(cfg_reg_t'(r), COORD_W'($urandom));
            case (phase % 4)
                0: write_reg(REG_FALLOFF, COORD_W'($urandom_range(0, 32'h40000)));
                1: write_reg(REG_FALLOFF, COORD_W'($urandom_range(0, 32'h400)));
                2: write_reg(REG_FALLOFF, COORD_W'($urandom));
                default: write_reg(REG_FALLOFF, COORD_W'($urandom_range(0, 32'h40)));
            endcase
            for (int i = 0; i < 190; i++) begin
                spread = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 32'h60000);
                if ($urandom_range(0, 3) == 0) spread = $urandom_range(1, 32'h800);
                queue_vertex(center[0] + rand_coord(spread), center[1] + rand_coord(spread),
                             center[2] + rand_coord(spread));
            end
            drain();
        end
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
